[hdl/mbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg
// shared types and constants of the msb-first bit packer
// ----------------------------------------------------------------------------
package mbp_pkg;

   localparam int MAX_WRITE_BITS  = 32;
   localparam int VALUE_BITS      = 32;
   localparam int COUNT_BITS      = 6;
   localparam int BYTE_BITS       = 8;
   localparam int FILL_BITS       = 3;
   localparam int WORD_BITS       = VALUE_BITS + BYTE_BITS;
   localparam int BYTE_CNT_BITS   = 3;
   localparam int CMD_QUEUE_DEPTH = 2;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [VALUE_BITS-1:0] bits_value;
      logic [COUNT_BITS-1:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic                  flush;
      logic [COUNT_BITS-1:0] count;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage : mbp_pkg
`default_nettype wire

[hdl/mbp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_front
// accepts request items, saturates and masks them, drops empty writes and
// holds the commands in a short queue for the back end
// ----------------------------------------------------------------------------
module mbp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  wire  mbp_pkg::req_type req_data,
   output mbp_pkg::cmd_link_type cmd_link,
   input  wire                   cmd_pop
);

   localparam int DEPTH = mbp_pkg::CMD_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mbp_pkg::cmd_type       q_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   mbp_pkg::cmd_type       cmd_new;
   logic [mbp_pkg::COUNT_BITS-1:0] count_sat;
   logic [mbp_pkg::VALUE_BITS-1:0] value_mask;
   logic                   accept;
   logic                   enq;
   logic                   deq;

   assign req_full = (cnt_ff == FULL_CNT);
   assign accept   = req_push && !req_full;

   always_comb begin
      if (req_data.bit_count > mbp_pkg::COUNT_BITS'(mbp_pkg::MAX_WRITE_BITS)) begin
         count_sat = mbp_pkg::COUNT_BITS'(mbp_pkg::MAX_WRITE_BITS);
      end else begin
         count_sat = req_data.bit_count;
      end
      if (count_sat >= mbp_pkg::COUNT_BITS'(mbp_pkg::VALUE_BITS)) begin
         value_mask = '1;
      end else begin
         value_mask = ~({mbp_pkg::VALUE_BITS{1'b1}} << count_sat);
      end
      cmd_new.flush = (req_data.op == mbp_pkg::OP_FLUSH);
      cmd_new.count = count_sat;
      cmd_new.value = req_data.bits_value & value_mask;
   end

   // a write of zero bits changes nothing and is not queued
   assign enq = accept && (cmd_new.flush || (count_sat != '0));
   assign deq = cmd_pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (deq && !enq) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_link.valid = (cnt_ff != '0);
   assign cmd_link.cmd   = q_ff[rd_ptr_ff];

endmodule : mbp_front
`default_nettype wire

[hdl/mbp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_back
// merges queued commands into the partial byte and shifts out the finished
// bytes one per cycle through a result register while that register has room
// ----------------------------------------------------------------------------
module mbp_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  mbp_pkg::cmd_link_type  cmd_link,
   output logic                         cmd_pop,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output mbp_pkg::rsp_type             rsp_data
);

   localparam int VW = mbp_pkg::VALUE_BITS;
   localparam int BW = mbp_pkg::BYTE_BITS;
   localparam int WW = mbp_pkg::WORD_BITS;
   localparam int CW = mbp_pkg::COUNT_BITS;
   localparam int FW = mbp_pkg::FILL_BITS;
   localparam int NW = mbp_pkg::BYTE_CNT_BITS;

   logic                busy_ff, busy_in;
   logic [WW-1:0]       word_ff, word_in;
   logic [NW-1:0]       left_ff, left_in;
   logic [BW-1:0]       partial_ff, partial_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic                out_valid_ff, out_valid_in;
   mbp_pkg::rsp_type    out_ff, out_in;

   logic                out_room;
   logic                load;
   logic [CW-1:0]       lshift;
   logic [VW-1:0]       v_align;
   logic [WW-1:0]       merged;
   logic [CW-1:0]       total;
   logic [NW-1:0]       nbytes;
   logic [BW-1:0]       tail_byte;
   logic [BW-1:0]       flush_byte;
   logic [FW:0]         rshift;

   assign out_room = !out_valid_ff || rsp_pop;
   assign load     = !busy_ff && cmd_link.valid;
   assign cmd_pop  = load;

   // new bits left-aligned, then placed right after the bits already held
   always_comb begin
      lshift    = CW'(VW) - cmd_link.cmd.count;
      v_align   = cmd_link.cmd.value << lshift;
      merged    = {partial_ff, {VW{1'b0}}} | ({v_align, {BW{1'b0}}} >> fill_ff);
      total     = CW'(fill_ff) + cmd_link.cmd.count;
      nbytes    = total[CW-1:FW];
      tail_byte = merged[WW-1 -: BW];
      case (nbytes)
         3'd0:    tail_byte = merged[WW-1 -: BW];
         3'd1:    tail_byte = merged[WW-1-BW -: BW];
         3'd2:    tail_byte = merged[WW-1-2*BW -: BW];
         3'd3:    tail_byte = merged[WW-1-3*BW -: BW];
         3'd4:    tail_byte = merged[WW-1-4*BW -: BW];
         default: tail_byte = '0;
      endcase
      rshift     = (FW+1)'(BW) - {1'b0, fill_ff};
      flush_byte = partial_ff >> rshift;
   end

   always_comb begin
      busy_in      = busy_ff;
      word_in      = word_ff;
      left_in      = left_ff;
      partial_in   = partial_ff;
      fill_in      = fill_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;

      if (busy_ff && out_room) begin
         out_valid_in    = 1'b1;
         out_in.out_byte = word_ff[WW-1 -: BW];
         out_in.last     = (left_ff == NW'(1));
         word_in         = word_ff << BW;
         left_in         = left_ff - 1'b1;
         busy_in         = (left_ff != NW'(1));
      end

      if (load) begin
         if (cmd_link.cmd.flush) begin
            // leftover bits go out right-aligned
            busy_in    = (fill_ff != '0);
            word_in    = {flush_byte, {VW{1'b0}}};
            left_in    = NW'(1);
            partial_in = '0;
            fill_in    = '0;
         end else begin
            busy_in    = (nbytes != '0);
            word_in    = merged;
            left_in    = nbytes;
            partial_in = tail_byte;
            fill_in    = total[FW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         left_ff      <= '0;
         partial_ff   <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         left_ff      <= left_in;
         partial_ff   <= partial_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      out_ff  <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule : mbp_back
`default_nettype wire

[hdl/msb_first_bit_packer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// packs variable-length bit fields msb first into bytes
// ----------------------------------------------------------------------------
// usage: push request items while full is low. an append item adds the low
// bit_count bits (0 to 32, larger counts saturate) of bits_value to the
// stream; a flush item sends any 1 to 7 leftover bits as one right-aligned
// byte and clears the partial byte. appends of zero bits are dropped at the
// input. results are read like a queue: while rsp_empty is low the oldest
// byte sits on rsp_data, and pop takes it; last marks the final byte an item
// produced.
// path: a byte that an item completes passes the command queue, the merge
// word register and the result register before it shows on rsp_data.
// flow: the merge unit loads an item only when idle, then emits its bytes one
// per cycle while the result register has room; a 32-bit write closes four
// bytes. the two-entry command queue lets new items enter meanwhile.
// reset clears the queue, the partial byte and the result register. when
// the receiver stalls, the result register holds its byte, the merge unit
// waits, and full rises once the command queue has filled.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_push,
   output logic                   req_full,
   input  wire  mbp_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output mbp_pkg::rsp_type       rsp_data
);

   mbp_pkg::cmd_link_type cmd_link;
   logic                  cmd_pop;

   mbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_link (cmd_link),
      .cmd_pop  (cmd_pop)
   );

   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_link  (cmd_link),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule : msb_first_bit_packer_core
`default_nettype wire
